// ===== hdl/kth_pkg.sv =====
// kth_pkg: shared constants and types for the k-th largest stream tracker
// no dependencies; used by the interfaces and every module of the block
package kth_pkg;

    localparam int MAX_RANK   = 16;
    localparam int VALUE_BITS = 32;
    localparam int RANK_BITS  = 5;
    localparam int COUNT_BITS = $clog2(MAX_RANK + 1);
    localparam int IDX_BITS   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [RANK_BITS-1:0]         t_rank;
    typedef logic [COUNT_BITS-1:0]        t_count;
    typedef logic [IDX_BITS-1:0]          t_idx;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic do_insert;
        logic load_result;
    } t_kth_cmd;

endpackage

// ===== hdl/kth_in_if.sv =====
// kth_in_if: input channel carrying one stream value per beat
// depends on kth_pkg
interface kth_in_if;
    import kth_pkg::*;

    logic   valid;
    logic   ready;
    t_value sample_value;
    logic   end_of_stream;

    modport source (output valid, output sample_value, output end_of_stream, input ready);
    modport sink   (input valid, input sample_value, input end_of_stream, output ready);
endinterface

// ===== hdl/kth_out_if.sv =====
// kth_out_if: result channel carrying the k-th largest value per beat
// depends on kth_pkg
interface kth_out_if;
    import kth_pkg::*;

    logic   valid;
    logic   ready;
    t_value kth_value;
    logic   kth_found;

    modport source (output valid, output kth_value, output kth_found, input ready);
    modport sink   (input valid, input kth_value, input kth_found, output ready);
endinterface

// ===== hdl/kth_cfg_if.sv =====
// kth_cfg_if: configuration write channel for the rank register
// depends on kth_pkg
interface kth_cfg_if;
    import kth_pkg::*;

    logic  valid;
    logic  ready;
    t_rank rank_k;

    modport source (output valid, output rank_k, input ready);
    modport sink   (input valid, input rank_k, output ready);
endinterface

// ===== hdl/kth_largest_stream_tracker_top.sv =====
// kth_largest_stream_tracker_top: reports the k-th largest value of a signed stream
// an input beat is registered, inserted into the store, then loaded as a result
// one item in flight (accept, insert, report); the report waits for a free output
// the next value is taken while a result waits in the output register
// reset (synchronous, active low) empties the store and sets the rank to one
// depends on kth_pkg, kth_in_if, kth_out_if, kth_cfg_if, kth_ctrl, kth_dp
module kth_largest_stream_tracker_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kth_in_if.sink    i_in,
    kth_out_if.source o_out,
    kth_cfg_if.sink   i_cfg
);
    import kth_pkg::*;

    t_kth_cmd cmd;

    // rank register is a plain write, always accepted
    assign i_cfg.ready = 1'b1;

    // controller: one item in flight, result held until taken
    kth_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // datapath: sorted store of the largest values, largest first
    kth_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_sample_value  (i_in.sample_value),
        .i_end_of_stream (i_in.end_of_stream),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_rank      (i_cfg.rank_k),
        .o_kth_value     (o_out.kth_value),
        .o_kth_found     (o_out.kth_found)
    );

    // the controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_item, cmd.do_insert, cmd.load_result}))
        else $error("more than one datapath command in a cycle");

    // an accepted beat is inserted in the following cycle
    a_insert_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> cmd.do_insert)
        else $error("insert did not follow an input beat");

    // loading a result always presents it on the output
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_result |=> o_out.valid)
        else $error("loaded result not presented");

    // a miss reports all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.kth_found) |-> (o_out.kth_value == '1))
        else $error("not-found result with a value other than -1");

endmodule

// ===== hdl/kth_ctrl.sv =====
// kth_ctrl: sequencer for accept, insert and report of one item
// depends on kth_pkg
module kth_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output kth_pkg::t_kth_cmd o_cmd
);
    import kth_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REPORT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.do_insert = 1'b1;
                n_state         = S_REPORT;
            end
            S_REPORT: begin
                // wait for the result register to be free
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/kth_dp.sv =====
// kth_dp: sorted value store with parallel compare-and-shift insert
// depends on kth_pkg; driven by kth_ctrl commands
module kth_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kth_pkg::t_kth_cmd i_cmd,
    input  kth_pkg::t_value   i_sample_value,
    input  logic              i_end_of_stream,
    input  logic              i_cfg_valid,
    input  kth_pkg::t_rank    i_cfg_rank,
    output kth_pkg::t_value   o_kth_value,
    output logic              o_kth_found
);
    import kth_pkg::*;

    t_value r_top [MAX_RANK];
    t_value n_top [MAX_RANK];
    t_count r_held;
    t_rank  r_rank;
    t_value r_sample;
    logic   r_eos;
    t_value r_kth_value;
    logic   r_kth_found;

    logic [MAX_RANK-1:0] keep;
    t_rank               eff_rank;
    t_rank               rank_m1;
    t_idx                rd_idx;
    logic                found;

    assign o_kth_value = r_kth_value;
    assign o_kth_found = r_kth_found;

    // entries at or above the new value stay put; the rest shift down one
    always_comb begin
        for (int i = 0; i < MAX_RANK; i++) begin
            keep[i] = (t_count'(i) < r_held) && (r_top[i] >= r_sample);
        end
        n_top[0] = keep[0] ? r_top[0] : r_sample;
        for (int i = 1; i < MAX_RANK; i++) begin
            if (keep[i]) begin
                n_top[i] = r_top[i];
            end else if (keep[i-1]) begin
                n_top[i] = r_sample;
            end else begin
                n_top[i] = r_top[i-1];
            end
        end
    end

    // rank zero reads as the maximum
    assign eff_rank = (r_rank == '0) ? t_rank'(1) : r_rank;
    assign rank_m1  = eff_rank - t_rank'(1);
    assign rd_idx   = t_idx'(rank_m1);
    assign found    = (int'(eff_rank) <= MAX_RANK) && (int'(r_held) >= int'(eff_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_rank <= t_rank'(1);
        end else begin
            if (i_cfg_valid) begin
                r_rank <= i_cfg_rank;
            end
            if (i_cmd.do_insert && (int'(r_held) != MAX_RANK)) begin
                r_held <= r_held + t_count'(1);
            end
            if (i_cmd.load_result && r_eos) begin
                r_held <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sample <= i_sample_value;
            r_eos    <= i_end_of_stream;
        end
        if (i_cmd.do_insert) begin
            r_top <= n_top;
        end
        if (i_cmd.load_result) begin
            r_kth_found <= found;
            r_kth_value <= found ? r_top[rd_idx] : '1;
        end
    end

endmodule

// ===== tb/sv/tb_kth_largest_stream_tracker_top.sv =====
`timescale 1ns / 100ps
// tb_kth_largest_stream_tracker_top: self-checking bench for the k-th largest stream tracker
// drives random and directed streams and checks each report against its own top-k model
// depends on kth_pkg, kth_in_if, kth_out_if, kth_cfg_if, kth_largest_stream_tracker_top
module tb_kth_largest_stream_tracker_top;
    import kth_pkg::*;

    localparam t_value VALUE_MAX       = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VALUE_MIN       = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_value NOT_FOUND_VALUE = -1;
    localparam int     ITEMS_PER_RANK  = 162;
    localparam int     SETTLE_CYCLES   = 8;

    // one input beat and one result beat
    typedef struct packed {
        t_value value;
        logic   last;
    } t_sample;

    typedef struct packed {
        t_value value;
        logic   found;
    } t_report;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kth_in_if  in_ch ();
    kth_out_if out_ch ();
    kth_cfg_if cfg_ch ();

    kth_largest_stream_tracker_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // ranks for the random phases: extremes, zero, out of range and a few in between
    t_rank rank_plan [12] = '{5'd1, 5'd16, 5'd8, 5'd0, 5'd31, 5'd3,
                              5'd17, 5'd12, 5'd2, 5'd16, 5'd5, 5'd1};

    // stimulus waiting for the driver and reports waiting for the block
    t_sample samples_to_send [$];
    t_report kth_reports_due [$];

    // model state: largest values of the current stream, descending, and the rank
    t_value top_held [MAX_RANK];
    int     held_n   = 0;
    t_rank  rank_now = 5'd1;

    // handshake flags seen at the last rising edge, used by the falling-edge drivers
    logic in_took  = 1'b0;
    logic out_took = 1'b0;

    // idle pattern state for both sides
    int in_gap     = 0;
    int out_wait   = 0;
    bit in_steady  = 1'b0;
    bit out_steady = 1'b0;

    // run statistics
    int n_checked     = 0;
    int n_found       = 0;
    int n_streams     = 0;
    int n_rank_writes = 0;
    int n_mismatch    = 0;

    // insert one value into the held list and report the k-th largest
    function automatic t_report predict_kth_report(input t_value v, input logic last);
        int      pos;
        int      k;
        t_report r;
        pos = 0;
        // equal values stay ahead of the newcomer
        while (pos < held_n && top_held[pos] >= v)
            pos++;
        // a full list drops a value no larger than its smallest
        if (pos < MAX_RANK) begin
            if (held_n < MAX_RANK)
                held_n++;
            for (int i = held_n - 1; i > pos; i--)
                top_held[i] = top_held[i-1];
            top_held[pos] = v;
        end
        // rank zero means the maximum; ranks past the store never find anything
        k = (rank_now == 0) ? 1 : int'(rank_now);
        if (k <= MAX_RANK && held_n >= k) begin
            r.value = top_held[k-1];
            r.found = 1'b1;
        end else begin
            r.value = NOT_FOUND_VALUE;
            r.found = 1'b0;
        end
        // the last value of a stream is reported, then the list is emptied
        if (last)
            held_n = 0;
        return r;
    endfunction

    // value mix: many near zero for duplicates, sixteen-bit range, full range for bit coverage, extremes
    function automatic t_value draw_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case (r[1:0])
                    2'd0: return VALUE_MIN;
                    2'd1: return VALUE_MAX;
                    2'd2: return NOT_FOUND_VALUE;
                    default: return '0;
                endcase
            end
            1, 2, 3: return t_value'(r);
            8, 9: return t_value'($signed({{16{r[15]}}, r[15:0]}));
            default: return t_value'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    task automatic queue_sample(input t_value v, input logic last);
        t_sample s;
        s.value = v;
        s.last  = last;
        samples_to_send.insert(samples_to_send.size(), s);
    endtask

    // wait until every beat is sent and reported, then let the pipeline drain
    task automatic settle_block();
        while (samples_to_send.size() != 0 || in_ch.valid || kth_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rank(input t_rank r);
        @(negedge clk);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.rank_k <= r;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        n_rank_writes++;
    endtask

    // input driver: presents queued samples, with a random gap after each beat
    always @(negedge clk) begin : drive_samples
        t_sample s;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (in_gap > 0) begin
                in_gap      <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
                s = samples_to_send.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.sample_value  <= s.value;
                in_ch.end_of_stream <= s.last;
                // now and then switch between back-to-back beats and random gaps
                if ($urandom_range(0, 15) == 0)
                    in_steady = !in_steady;
                in_gap <= in_steady ? 0 : $urandom_range(0, 7);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: stalls a random number of cycles after each accepted beat
    always @(negedge clk) begin : drive_ready
        int w;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_took && $urandom_range(0, 15) == 0)
                out_steady = !out_steady;
            w = out_took ? (out_steady ? 0 : $urandom_range(0, 7)) : out_wait;
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                out_wait     <= w - 1;
            end else begin
                out_ch.ready <= 1'b1;
                out_wait     <= 0;
            end
        end
    end

    // monitor: tracks rank writes, predicts on input beats, checks result beats
    always @(posedge clk) begin : watch_beats
        t_report due;
        if (!rst_n) begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end else begin
            in_took  <= in_ch.valid && in_ch.ready;
            out_took <= out_ch.valid && out_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
                rank_now = cfg_ch.rank_k;
            if (in_ch.valid && in_ch.ready) begin
                kth_reports_due.insert(kth_reports_due.size(),
                    predict_kth_report(in_ch.sample_value, in_ch.end_of_stream));
                if (in_ch.end_of_stream)
                    n_streams++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (kth_reports_due.size() == 0) begin
                    $error("result beat with no report pending: kth_value %0d kth_found %0b",
                           out_ch.kth_value, out_ch.kth_found);
                    n_mismatch++;
                end else begin
                    due = kth_reports_due.pop_front();
                    n_checked++;
                    if (due.found)
                        n_found++;
                    if (out_ch.kth_value !== due.value) begin
                        $error("kth_value: expected %0d, got %0d", due.value, out_ch.kth_value);
                        n_mismatch++;
                    end
                    if (out_ch.kth_found !== due.found) begin
                        $error("kth_found: expected %0b, got %0b", due.found, out_ch.kth_found);
                        n_mismatch++;
                    end
                end
            end
        end
    end

    // main sequence: reset, directed streams, then random phases at each rank
    initial begin : run_streams
        int stream_left;
        int i;
        stream_left = 0;
        in_ch.valid         = 1'b0;
        in_ch.sample_value  = '0;
        in_ch.end_of_stream = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.rank_k       = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // default rank after reset: the maximum, over both extremes and a repeat
        queue_sample(VALUE_MIN, 1'b0);
        queue_sample(VALUE_MAX, 1'b0);
        queue_sample(VALUE_MAX, 1'b0);
        queue_sample('0, 1'b1);
        settle_block();

        // fill all sixteen entries with duplicates, then one equal to the smallest
        // (dropped) and one above it (evicts the smallest)
        write_rank(5'd16);
        for (i = 0; i < MAX_RANK; i++)
            queue_sample((i % 4 == 0) ? t_value'(50) : t_value'(i * 13 - 100), 1'b0);
        queue_sample(t_value'(-87), 1'b0);
        queue_sample(t_value'(60), 1'b0);
        settle_block();

        // rank changes while the stream is still open: zero acts as one,
        // seventeen is past the store and never finds
        write_rank(5'd0);
        queue_sample(NOT_FOUND_VALUE, 1'b0);
        settle_block();
        write_rank(5'd17);
        queue_sample(t_value'(1), 1'b1);
        settle_block();

        // random streams; lengths often exceed the store, some cross rank changes
        foreach (rank_plan[p]) begin
            write_rank(rank_plan[p]);
            for (i = 0; i < ITEMS_PER_RANK; i++) begin
                if (stream_left == 0)
                    stream_left = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                               : $urandom_range(1, 40);
                stream_left--;
                queue_sample(draw_value(), stream_left == 0);
            end
            settle_block();
        end

        $display("checked %0d reports (%0d found) over %0d closed streams",
                 n_checked, n_found, n_streams);
        $display("rank register written %0d times, from 0 through 31", n_rank_writes);
        if (n_mismatch == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d reports still due", kth_reports_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
